FILE: rtl/core/pstk_pkg.sv
// ----------------------------------------------------------------------------
// pstk_pkg: shared types and constants of the prime scan unit
// Field widths, item structs, result kinds and the sequencer state type.
// ----------------------------------------------------------------------------
package pstk_pkg;

  // width of the tested number and depth of the top-prime store
  localparam int NUM_BITS  = 27;
  localparam int TOP_COUNT = 10;

  // fixed field widths
  localparam int CAND_W  = 27;
  localparam int COUNT_W = 28;
  localparam int SUM_W   = 64;
  localparam int TOP_W   = 27;

  // derived widths
  localparam int DIV_W  = (NUM_BITS + 1) / 2 + 2;  // odd divisor, just past sqrt
  localparam int SQ_W   = NUM_BITS + 1;            // divisor squared
  localparam int BIT_W  = $clog2(NUM_BITS);        // bit index into the number
  localparam int FILL_W = $clog2(TOP_COUNT + 1);
  localparam int IDX_W  = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

  // result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_LIST    = 1'b1;

  typedef logic [NUM_BITS-1:0] num_t;

  typedef struct packed {
    logic [CAND_W-1:0] candidate;
    logic              end_of_range;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic               is_prime;
    logic [COUNT_W-1:0] prime_count;
    logic [SUM_W-1:0]   prime_sum;
    logic [TOP_W-1:0]   top_prime;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_VERDICT,
    ST_LIST
  } state_e;

endpackage

FILE: rtl/core/prime_scan_with_top_k_unit.sv
// ----------------------------------------------------------------------------
// prime_scan_with_top_k_unit: trial-division prime scanner with top-k keeper
// Tests each number by bit-serial remainders against odd divisors, keeps a
// running count and saturating sum and the largest primes, lists on range end.
// ----------------------------------------------------------------------------
// Flow: a check state sends numbers below 2 and even numbers straight to the
//   verdict, 2 and odd primes below 9 through an update first; each odd divisor
//   tried adds a bit-serial remainder and one check, about sqrt(n)/2 of them.
// Throughput: one number at a time, input stalled until its verdict and any listing
//   are loaded; a range end lists one kept prime per cycle unless the output stalls.
//   Reset: asynchronous, active low; clears control, count, sum and fill, not the store.
module prime_scan_with_top_k_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pstk_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pstk_pkg::out_item_t out_data_o
);
  import pstk_pkg::*;

  state_e state_q, state_d;

  // number under test and its run flags
  num_t                v_q;
  logic                last_q;
  logic                prime_q;
  // trial divisor, its square and the serial remainder
  logic [DIV_W-1:0]    d_q;
  logic [SQ_W-1:0]     sq_q;
  logic [DIV_W-1:0]    rem_q;
  logic [BIT_W-1:0]    bit_cnt_q;
  // running totals and top store
  logic [COUNT_W-1:0]  count_q;
  logic [SUM_W-1:0]    sum_q;
  num_t                store_q [TOP_COUNT];
  logic [FILL_W-1:0]   fill_q;
  logic [IDX_W-1:0]    list_idx_q;
  // output register
  logic                out_valid_q;
  out_item_t           out_q;

  logic in_xfer, out_free;
  logic chk_composite, chk_prime;
  logic [DIV_W:0]   shifted;
  logic [DIV_W-1:0] rem_nx;
  logic             div_last;
  logic             list_last;
  logic             store_full;
  logic             keep_ok;
  logic [SUM_W:0]   sum_ext;
  logic             load_verdict, load_list, clear_run;
  num_t             ins_store [TOP_COUNT];
  logic [TOP_COUNT-1:0] gt, lt;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // quick verdicts before trial division
  assign chk_composite = (v_q < NUM_BITS'(2)) || ((v_q != NUM_BITS'(2)) && !v_q[0]);
  assign chk_prime     = (v_q == NUM_BITS'(2)) || (sq_q > {1'b0, v_q});

  // one restoring step of the serial remainder
  assign shifted  = {rem_q, v_q[bit_cnt_q]};
  assign rem_nx   = (shifted >= {1'b0, d_q}) ? DIV_W'(shifted - {1'b0, d_q})
                                             : DIV_W'(shifted);
  assign div_last = (bit_cnt_q == '0);

  assign list_last  = ((FILL_W'(list_idx_q) + FILL_W'(1)) == fill_q);
  assign store_full = (fill_q == FILL_W'(TOP_COUNT));
  assign keep_ok    = !store_full || (v_q > store_q[0]);
  assign sum_ext    = {1'b0, sum_q} + (SUM_W + 1)'(v_q);

  // sorted insert, each slot decides from its neighbors
  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_ins
    logic from_below, from_above, take_nf, take_f;
    assign gt[i] = (FILL_W'(i) < fill_q) && (store_q[i] > v_q);
    assign lt[i] = (store_q[i] < v_q);
    if (i > 0) begin : g_below
      assign from_below = gt[i-1];
    end else begin : g_nobelow
      assign from_below = 1'b0;
    end
    if (i < TOP_COUNT - 1) begin : g_above
      assign from_above = lt[i+1];
    end else begin : g_noabove
      assign from_above = 1'b0;
    end
    assign take_nf = !from_below && (gt[i] || (FILL_W'(i) == fill_q));
    assign take_f  = !from_above && ((i == 0) || lt[i]);
    always_comb begin
      if (!store_full) begin
        if (from_below) begin
          ins_store[i] = store_q[(i > 0) ? i - 1 : 0];
        end else if (take_nf) begin
          ins_store[i] = v_q;
        end else begin
          ins_store[i] = store_q[i];
        end
      end else begin
        if (from_above) begin
          ins_store[i] = store_q[(i < TOP_COUNT - 1) ? i + 1 : i];
        end else if (take_f) begin
          ins_store[i] = v_q;
        end else begin
          ins_store[i] = store_q[i];
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (chk_composite) state_d = ST_VERDICT;
        else if (chk_prime) state_d = ST_UPDATE;
        else state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_last) state_d = (rem_nx == '0) ? ST_VERDICT : ST_CHECK;
      end
      ST_UPDATE: state_d = ST_VERDICT;
      ST_VERDICT: begin
        if (out_free) begin
          if (last_q && (fill_q != '0)) state_d = ST_LIST;
          else state_d = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (out_free && list_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    load_verdict = (state_q == ST_VERDICT) && out_free;
    load_list    = (state_q == ST_LIST) && out_free;
    clear_run    = (load_verdict && last_q && (fill_q == '0)) || (load_list && list_last);
  end

  // control and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      sum_q       <= '0;
      fill_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load_verdict || load_list) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (clear_run) begin
        count_q <= '0;
        sum_q   <= '0;
        fill_q  <= '0;
      end else if (state_q == ST_UPDATE) begin
        if (count_q != '1) count_q <= count_q + COUNT_W'(1);
        sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        if (!store_full) fill_q <= fill_q + FILL_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      v_q    <= NUM_BITS'(in_data_i.candidate);
      last_q <= in_data_i.end_of_range;
      d_q    <= DIV_W'(3);
      sq_q   <= SQ_W'(9);
    end
    if (state_q == ST_CHECK) begin
      prime_q   <= !chk_composite && chk_prime;
      rem_q     <= '0;
      bit_cnt_q <= BIT_W'(NUM_BITS - 1);
    end
    if (state_q == ST_DIV) begin
      rem_q     <= rem_nx;
      bit_cnt_q <= bit_cnt_q - BIT_W'(1);
      if (div_last) begin
        prime_q <= 1'b0;
        d_q     <= d_q + DIV_W'(2);
        sq_q    <= sq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
      end
    end
    if ((state_q == ST_UPDATE) && keep_ok) begin
      for (int i = 0; i < TOP_COUNT; i++) begin
        store_q[i] <= ins_store[i];
      end
    end
    if (state_q == ST_VERDICT) list_idx_q <= '0;
    else if (load_list) list_idx_q <= list_idx_q + IDX_W'(1);
    if (load_verdict) begin
      out_q.result_kind <= KIND_VERDICT;
      out_q.is_prime    <= prime_q;
      out_q.prime_count <= count_q;
      out_q.prime_sum   <= sum_q;
      out_q.top_prime   <= '0;
      out_q.last_of_run <= !(last_q && (fill_q != '0));
    end else if (load_list) begin
      out_q.result_kind <= KIND_LIST;
      out_q.is_prime    <= 1'b0;
      out_q.prime_count <= count_q;
      out_q.prime_sum   <= sum_q;
      out_q.top_prime   <= TOP_W'(store_q[list_idx_q]);
      out_q.last_of_run <= list_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/pstk_sva.sv
// ----------------------------------------------------------------------------
// pstk_sva: port-level checks of the prime scan unit
// Handshake hold rules and block behavior seen on the ports, bound to the top.
// ----------------------------------------------------------------------------
module pstk_sva (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pstk_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pstk_pkg::out_item_t out_data_o
);
  import pstk_pkg::*;

  // a stalled number stays offered with the same payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input changed while stalled");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // one number at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a number is in work");

  // listing entries carry no verdict
  a_list_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == KIND_LIST) |-> !out_data_o.is_prime)
    else $error("listing entry flagged as verdict");

endmodule

bind prime_scan_with_top_k_unit pstk_sva u_pstk_sva (.*);
